>>> design/p2m_pkg.sv
// ----------------------------------------------------------------------------
// Point to Morton code package
// Shared types and constants for the point to Morton code encoder.
// ----------------------------------------------------------------------------
package p2m_pkg;

    localparam int AXES  = 3;
    localparam int MIN_W = 32;
    localparam int EXT_W = 31;
    localparam int APB_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [MIN_W-1:0] MIN_RESET    = 32'd0;
    localparam logic [EXT_W-1:0] EXTENT_RESET = 31'd65536;

    // Register indexes, taken from byte address bit 2.
    localparam logic REG_MIN    = 1'b0;
    localparam logic REG_EXTENT = 1'b1;

    typedef struct packed {
        logic            last;
        logic            clamped;
        logic [AXES-1:0] force_max;
    } ctl_t;

endpackage

>>> design/p2m_front.sv
// ----------------------------------------------------------------------------
// Point to Morton code front stage
// Offsets each coordinate, detects points outside the cube and registers the
// starting remainder of each division.
// ----------------------------------------------------------------------------
module p2m_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              in_valid,
    output logic                                              in_ready,
    input  logic signed [COORD_WIDTH-1:0]                     in_x_coord,
    input  logic signed [COORD_WIDTH-1:0]                     in_y_coord,
    input  logic signed [COORD_WIDTH-1:0]                     in_z_coord,
    input  logic                                              in_last,
    input  logic [p2m_pkg::MIN_W-1:0]                         min_coordinate,
    input  logic [p2m_pkg::EXT_W-1:0]                         cube_extent,
    output logic                                              out_valid,
    input  logic                                              out_ready,
    output p2m_pkg::ctl_t                                     out_ctl,
    output logic [p2m_pkg::AXES-1:0][p2m_pkg::EXT_W-1:0]      out_rem
);

    localparam int CMP_W = (COORD_WIDTH > p2m_pkg::EXT_W) ? COORD_WIDTH : p2m_pkg::EXT_W;

    logic                                         valid_reg;
    p2m_pkg::ctl_t                                ctl_reg;
    p2m_pkg::ctl_t                                ctl_next;
    logic [p2m_pkg::AXES-1:0][p2m_pkg::EXT_W-1:0] rem_reg;
    logic [p2m_pkg::AXES-1:0][p2m_pkg::EXT_W-1:0] rem_next;

    logic [p2m_pkg::AXES-1:0][COORD_WIDTH-1:0]    coords;
    logic [COORD_WIDTH-1:0]                       sign_bit;
    logic [COORD_WIDTH-1:0]                       min_biased;
    logic [p2m_pkg::AXES-1:0][COORD_WIDTH:0]      diff;
    logic [p2m_pkg::AXES-1:0][CMP_W-1:0]          span;
    logic [CMP_W-1:0]                             extent_cmp;
    logic [p2m_pkg::AXES-1:0]                     below;
    logic [p2m_pkg::AXES-1:0]                     above;

    assign coords     = {in_z_coord, in_y_coord, in_x_coord};
    assign sign_bit   = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    assign min_biased = COORD_WIDTH'(min_coordinate) ^ sign_bit;
    assign extent_cmp = CMP_W'(cube_extent);

    // Offset binary keeps the order, so a plain unsigned subtract gives the distance.
    always_comb begin
        for (int a = 0; a < p2m_pkg::AXES; a++) begin
            diff[a]     = {1'b0, coords[a] ^ sign_bit} - {1'b0, min_biased};
            span[a]     = CMP_W'(diff[a][COORD_WIDTH-1:0]);
            below[a]    = diff[a][COORD_WIDTH];
            above[a]    = !below[a] && (span[a] >= extent_cmp);
            rem_next[a] = (below[a] || above[a]) ? '0 : span[a][p2m_pkg::EXT_W-1:0];
        end
        ctl_next.last      = in_last;
        ctl_next.clamped   = |(below | above);
        ctl_next.force_max = above;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            ctl_reg <= ctl_next;
            rem_reg <= rem_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_rem   = rem_reg;

endmodule

>>> design/p2m_cell.sv
// ----------------------------------------------------------------------------
// Point to Morton code division cell
// One restoring division step for all three axes, producing one quotient bit
// per axis and handing the remainder to the next cell.
// ----------------------------------------------------------------------------
module p2m_cell #(
    parameter int LEVEL_BITS = 10
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic [p2m_pkg::EXT_W-1:0]                         cube_extent,
    input  logic                                              in_valid,
    output logic                                              in_ready,
    input  p2m_pkg::ctl_t                                     in_ctl,
    input  logic [p2m_pkg::AXES-1:0][p2m_pkg::EXT_W-1:0]      in_rem,
    input  logic [p2m_pkg::AXES-1:0][LEVEL_BITS-1:0]          in_quo,
    output logic                                              out_valid,
    input  logic                                              out_ready,
    output p2m_pkg::ctl_t                                     out_ctl,
    output logic [p2m_pkg::AXES-1:0][p2m_pkg::EXT_W-1:0]      out_rem,
    output logic [p2m_pkg::AXES-1:0][LEVEL_BITS-1:0]          out_quo
);

    logic                                         valid_reg;
    p2m_pkg::ctl_t                                ctl_reg;
    logic [p2m_pkg::AXES-1:0][p2m_pkg::EXT_W-1:0] rem_reg;
    logic [p2m_pkg::AXES-1:0][p2m_pkg::EXT_W-1:0] rem_next;
    logic [p2m_pkg::AXES-1:0][LEVEL_BITS-1:0]     quo_reg;
    logic [p2m_pkg::AXES-1:0][LEVEL_BITS-1:0]     quo_next;

    logic [p2m_pkg::AXES-1:0][p2m_pkg::EXT_W:0]   doubled;
    logic [p2m_pkg::AXES-1:0][p2m_pkg::EXT_W:0]   reduced;
    logic [p2m_pkg::AXES-1:0][LEVEL_BITS:0]       quo_shift;
    logic [p2m_pkg::AXES-1:0]                     fits;
    logic [p2m_pkg::EXT_W:0]                      divisor;

    assign divisor = {1'b0, cube_extent};

    // The remainder stays below the extent, so the doubled value fits one extra bit.
    always_comb begin
        for (int a = 0; a < p2m_pkg::AXES; a++) begin
            doubled[a]   = {in_rem[a], 1'b0};
            reduced[a]   = doubled[a] - divisor;
            fits[a]      = doubled[a] >= divisor;
            rem_next[a]  = fits[a] ? reduced[a][p2m_pkg::EXT_W-1:0]
                                   : doubled[a][p2m_pkg::EXT_W-1:0];
            quo_shift[a] = {in_quo[a], fits[a]};
            quo_next[a]  = quo_shift[a][LEVEL_BITS-1:0];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            ctl_reg <= in_ctl;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;

endmodule

>>> design/p2m_pack.sv
// ----------------------------------------------------------------------------
// Point to Morton code output stage
// Applies saturation, interleaves the three quantised axes and holds the
// result beat until it is taken.
// ----------------------------------------------------------------------------
module p2m_pack #(
    parameter int LEVEL_BITS = 10
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  p2m_pkg::ctl_t                            in_ctl,
    input  logic [p2m_pkg::AXES-1:0][LEVEL_BITS-1:0] in_quo,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic [p2m_pkg::AXES*LEVEL_BITS-1:0]      out_morton_code,
    output logic                                     out_clamped,
    output logic                                     out_last_point
);

    logic                                     valid_reg;
    logic [p2m_pkg::AXES*LEVEL_BITS-1:0]      code_reg;
    logic [p2m_pkg::AXES*LEVEL_BITS-1:0]      code_next;
    logic                                     clamped_reg;
    logic                                     last_reg;
    logic [p2m_pkg::AXES-1:0][LEVEL_BITS-1:0] level;

    always_comb begin
        for (int a = 0; a < p2m_pkg::AXES; a++) begin
            level[a] = in_quo[a] | {LEVEL_BITS{in_ctl.force_max[a]}};
        end
        for (int k = 0; k < LEVEL_BITS; k++) begin
            for (int a = 0; a < p2m_pkg::AXES; a++) begin
                code_next[p2m_pkg::AXES*k + a] = level[a][k];
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            code_reg    <= code_next;
            clamped_reg <= in_ctl.clamped;
            last_reg    <= in_ctl.last;
        end
    end

    assign out_valid       = valid_reg;
    assign out_morton_code = code_reg;
    assign out_clamped     = clamped_reg;
    assign out_last_point  = last_reg;

endmodule

>>> design/point_to_morton_code_top.sv
// ----------------------------------------------------------------------------
// Point to Morton code encoder
// Quantises a 3D point into the bounding cube and interleaves the axes into
// a Morton code, using a row of division cells, one per level bit.
// ----------------------------------------------------------------------------
// Each beat is registered in turn by the front stage, every division cell and the output stage.
// Throughput: one beat per cycle while the output is not stalled; each division cell yields one quotient bit.
// A stalled output holds the row, and every stage keeps its beat until it moves.
// Reset clears all stage valids, sets min_coordinate to 0 and cube_extent to 65536.
module point_to_morton_code_top #(
    parameter int LEVEL_BITS  = 10,
    parameter int COORD_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [p2m_pkg::ADDR_W-1:0]         paddr,
    input  logic [p2m_pkg::APB_W-1:0]          pwdata,
    output logic [p2m_pkg::APB_W-1:0]          prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [COORD_WIDTH-1:0]      s_x_coord,
    input  logic signed [COORD_WIDTH-1:0]      s_y_coord,
    input  logic signed [COORD_WIDTH-1:0]      s_z_coord,
    input  logic                               s_last_point_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [3*LEVEL_BITS-1:0]            m_morton_code,
    output logic                               m_clamped,
    output logic                               m_last_point_out
);

    logic [p2m_pkg::MIN_W-1:0] min_reg;
    logic [p2m_pkg::EXT_W-1:0] extent_reg;
    logic                      cfg_write;

    logic          chain_valid [LEVEL_BITS+1];
    logic          chain_ready [LEVEL_BITS+1];
    p2m_pkg::ctl_t chain_ctl   [LEVEL_BITS+1];
    logic [p2m_pkg::AXES-1:0][p2m_pkg::EXT_W-1:0] chain_rem [LEVEL_BITS+1];
    logic [p2m_pkg::AXES-1:0][LEVEL_BITS-1:0]     chain_quo [LEVEL_BITS+1];

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg    <= p2m_pkg::MIN_RESET;
            extent_reg <= p2m_pkg::EXTENT_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                p2m_pkg::REG_MIN:    min_reg    <= pwdata;
                p2m_pkg::REG_EXTENT: extent_reg <= pwdata[p2m_pkg::EXT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            p2m_pkg::REG_MIN:    prdata = min_reg;
            p2m_pkg::REG_EXTENT: prdata = {1'b0, extent_reg};
            default:             prdata = '0;
        endcase
    end

    p2m_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .in_x_coord     (s_x_coord),
        .in_y_coord     (s_y_coord),
        .in_z_coord     (s_z_coord),
        .in_last        (s_last_point_in),
        .min_coordinate (min_reg),
        .cube_extent    (extent_reg),
        .out_valid      (chain_valid[0]),
        .out_ready      (chain_ready[0]),
        .out_ctl        (chain_ctl[0]),
        .out_rem        (chain_rem[0])
    );

    assign chain_quo[0] = '0;

    for (genvar i = 0; i < LEVEL_BITS; i++) begin : g_cell
        p2m_cell #(
            .LEVEL_BITS (LEVEL_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cube_extent (extent_reg),
            .in_valid    (chain_valid[i]),
            .in_ready    (chain_ready[i]),
            .in_ctl      (chain_ctl[i]),
            .in_rem      (chain_rem[i]),
            .in_quo      (chain_quo[i]),
            .out_valid   (chain_valid[i+1]),
            .out_ready   (chain_ready[i+1]),
            .out_ctl     (chain_ctl[i+1]),
            .out_rem     (chain_rem[i+1]),
            .out_quo     (chain_quo[i+1])
        );
    end

    p2m_pack #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_pack (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (chain_valid[LEVEL_BITS]),
        .in_ready        (chain_ready[LEVEL_BITS]),
        .in_ctl          (chain_ctl[LEVEL_BITS]),
        .in_quo          (chain_quo[LEVEL_BITS]),
        .out_valid       (m_valid),
        .out_ready       (m_ready),
        .out_morton_code (m_morton_code),
        .out_clamped     (m_clamped),
        .out_last_point  (m_last_point_out)
    );

endmodule

>>> verif/tb_point_to_morton_code_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point to Morton code encoder testbench
// Streams 3D points through the encoder under several bounding cube settings
// written over the APB port. Every accepted point is quantised and
// interleaved by a local predictor. Each result beat is checked, field by
// field, against the oldest predicted code. Both channels idle at random but in the last two phases.
// ----------------------------------------------------------------------------
module tb_point_to_morton_code_top;

    localparam int LEVEL_BITS   = 10;
    localparam int COORD_WIDTH  = 32;
    localparam int CODE_W       = 3 * LEVEL_BITS;
    localparam int PHASES       = 6;
    localparam int RANDOM_ITEMS = 90;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [31:0] COORD_MIN = 32'h8000_0000;
    localparam logic [31:0] COORD_MAX = 32'h7fff_ffff;
    localparam longint      LONG_MIN  = -longint'(64'sd2147483648);
    localparam longint      LONG_MAX  = 64'sd2147483647;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [COORD_WIDTH-1:0] z;
        logic                   last;
    } point_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              clamped;
        logic              last;
    } code_beat_t;

    logic                           aclk    = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [p2m_pkg::ADDR_W-1:0]     paddr   = '0;
    logic [p2m_pkg::APB_W-1:0]      pwdata  = '0;
    logic [p2m_pkg::APB_W-1:0]      prdata;
    logic                           pready;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic signed [COORD_WIDTH-1:0]  s_x_coord = '0;
    logic signed [COORD_WIDTH-1:0]  s_y_coord = '0;
    logic signed [COORD_WIDTH-1:0]  s_z_coord = '0;
    logic                           s_last_point_in = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [CODE_W-1:0]              m_morton_code;
    logic                           m_clamped;
    logic                           m_last_point_out;

    logic signed [p2m_pkg::MIN_W-1:0] min_coordinate = p2m_pkg::MIN_RESET;
    logic [p2m_pkg::EXT_W-1:0]        cube_extent    = p2m_pkg::EXTENT_RESET;

    point_t     point_queue[$];
    point_t     point_on_bus;
    code_beat_t code_queue[$];
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         error_count    = 0;
    int         cycle_count    = 0;

    point_to_morton_code_top #(
        .LEVEL_BITS  (LEVEL_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_x_coord        (s_x_coord),
        .s_y_coord        (s_y_coord),
        .s_z_coord        (s_z_coord),
        .s_last_point_in  (s_last_point_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_morton_code    (m_morton_code),
        .m_clamped        (m_clamped),
        .m_last_point_out (m_last_point_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [LEVEL_BITS:0] quantise_axis(input logic [COORD_WIDTH-1:0] c);
        longint offset;
        longint scaled;
        offset = longint'($signed(c)) - longint'(min_coordinate);
        if (offset < 0) begin
            return {1'b1, {LEVEL_BITS{1'b0}}};
        end
        if (offset >= longint'(cube_extent)) begin
            return {1'b1, {LEVEL_BITS{1'b1}}};
        end
        scaled = (offset << LEVEL_BITS) / longint'(cube_extent);
        return {1'b0, scaled[LEVEL_BITS-1:0]};
    endfunction

    function automatic code_beat_t encode_point(input point_t p);
        logic [LEVEL_BITS:0] qx;
        logic [LEVEL_BITS:0] qy;
        logic [LEVEL_BITS:0] qz;
        code_beat_t          beat;
        qx = quantise_axis(p.x);
        qy = quantise_axis(p.y);
        qz = quantise_axis(p.z);
        for (int k = 0; k < LEVEL_BITS; k++) begin
            beat.code[3*k]     = qx[k];
            beat.code[3*k + 1] = qy[k];
            beat.code[3*k + 2] = qz[k];
        end
        beat.clamped = qx[LEVEL_BITS] | qy[LEVEL_BITS] | qz[LEVEL_BITS];
        beat.last    = p.last;
        return beat;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] pick_coord();
        longint c;
        int     kind;
        kind = $urandom_range(9);
        if (kind <= 5) begin
            c = longint'(min_coordinate) + longint'($urandom) % longint'(cube_extent);
        end else if (kind == 6) begin
            c = longint'(min_coordinate) + $urandom_range(6) - 3;
        end else if (kind == 7) begin
            c = longint'(min_coordinate) + longint'(cube_extent) + $urandom_range(6) - 3;
        end else begin
            c = longint'($signed($urandom));
        end
        if (c > LONG_MAX) begin
            c = LONG_MAX;
        end
        if (c < LONG_MIN) begin
            c = LONG_MIN;
        end
        return c[COORD_WIDTH-1:0];
    endfunction

    function automatic point_t random_point();
        point_t p;
        p.x    = pick_coord();
        p.y    = pick_coord();
        p.z    = pick_coord();
        p.last = 1'($urandom_range(1));
        return p;
    endfunction

    task automatic push_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic last);
        point_queue.push_back(point_t'{x: x, y: y, z: z, last: last});
    endtask

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (point_queue.size() != 0 || s_valid || code_queue.size() != 0);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [p2m_pkg::APB_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == p2m_pkg::REG_MIN) begin
            min_coordinate = data;
        end else begin
            cube_extent = data[p2m_pkg::EXT_W-1:0];
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                code_queue.push_back(encode_point(point_on_bus));
            end
            if (!s_valid || s_ready) begin
                if (point_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    point_on_bus    = point_queue.pop_front();
                    s_valid         <= 1'b1;
                    s_x_coord       <= point_on_bus.x;
                    s_y_coord       <= point_on_bus.y;
                    s_z_coord       <= point_on_bus.z;
                    s_last_point_in <= point_on_bus.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        code_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (code_queue.size() == 0) begin
                    $error("unexpected result beat, code %h", m_morton_code);
                    error_count++;
                end else begin
                    want = code_queue.pop_front();
                    if (m_morton_code !== want.code) begin
                        $error("morton_code: expected %h, got %h", want.code, m_morton_code);
                        error_count++;
                    end
                    if (m_clamped !== want.clamped) begin
                        $error("clamped: expected %b, got %b", want.clamped, m_clamped);
                        error_count++;
                    end
                    if (m_last_point_out !== want.last) begin
                        $error("last_point_out: expected %b, got %b", want.last,
                               m_last_point_out);
                        error_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_point_to_morton_code_top NOT OK");
            $finish;
        end
    end

    initial begin
        logic [31:0]               new_min;
        logic [p2m_pkg::EXT_W-1:0] new_extent;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct  = 26;
        recv_stall_pct = 57;
        push_point(32'd0, 32'd0, 32'd0, 1'b0);
        push_point(32'd65535, 32'd65535, 32'd65535, 1'b1);
        push_point(32'd65536, 32'd0, 32'd0, 1'b0);
        push_point(32'hffff_ffff, 32'd65535, 32'd32768, 1'b0);
        push_point(COORD_MIN, COORD_MAX, 32'd0, 1'b1);
        push_point(COORD_MAX, COORD_MIN, 32'd1, 1'b0);
        push_point(32'd64, 32'd128, 32'd192, 1'b0);
        push_point(32'd32768, 32'd16384, 32'd49152, 1'b1);
        push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        push_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        push_point(32'h0000_aaaa, 32'h0000_5555, 32'h0000_ffc0, 1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            send_idle_pct  = (phase < 2) ? 26 : (phase < 4) ? 57 : 0;
            recv_stall_pct = (phase < 2) ? 57 : (phase < 4) ? 26 : 0;
            case (phase)
                0: begin
                    new_min    = COORD_MIN;
                    new_extent = 31'd1;
                end
                1: begin
                    new_min    = -32'sd1000;
                    new_extent = 31'd1024;
                end
                2: begin
                    new_min    = $urandom;
                    new_extent = 31'($urandom_range(32'h7fff_ffff, 1));
                end
                3: begin
                    new_min    = COORD_MAX;
                    new_extent = 31'h7fff_ffff;
                end
                4: begin
                    new_min    = COORD_MIN;
                    new_extent = 31'h7fff_ffff;
                end
                default: begin
                    new_min    = $urandom;
                    new_extent = 31'($urandom_range(5000, 1));
                end
            endcase
            apb_write(p2m_pkg::REG_MIN, new_min);
            apb_write(p2m_pkg::REG_EXTENT, {1'b0, new_extent});
            @(negedge aclk);
            case (phase)
                0: begin
                    push_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
                    push_point(COORD_MIN + 32'd1, COORD_MIN, COORD_MAX, 1'b0);
                end
                3: begin
                    push_point(COORD_MAX, COORD_MAX - 32'd1, COORD_MIN, 1'b1);
                end
                4: begin
                    push_point(COORD_MAX, 32'hffff_fffe, 32'hffff_ffff, 1'b0);
                end
                default: ;
            endcase
            for (int i = 0; i < RANDOM_ITEMS; i++) begin
                if (phase == 2 && i == RANDOM_ITEMS / 2) begin
                    wait_drained();
                end
                point_queue.push_back(random_point());
            end
        end

        wait_drained();
        repeat (4 * (LEVEL_BITS + 2)) @(negedge aclk);
        if (code_queue.size() != 0) begin
            $error("%0d predicted codes never arrived", code_queue.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_point_to_morton_code_top OK");
        end else begin
            $display("tb_point_to_morton_code_top NOT OK");
        end
        $finish;
    end

endmodule

>>> point_to_morton_code_top.f
design/p2m_pkg.sv
design/p2m_front.sv
design/p2m_cell.sv
design/p2m_pack.sv
design/point_to_morton_code_top.sv
verif/tb_point_to_morton_code_top.sv
